/* src/tph_pkg.sv */
// Shared types and constants for the triangle point height block.
`timescale 1ns / 1ps

package tph_pkg;

    localparam int QW   = 25;   // vertex minus query, eight fraction bits
    localparam int DW   = 17;   // vertex coordinate differences
    localparam int PEW  = 50;   // edge partial products
    localparam int PW   = 35;   // plane coefficients and denominator
    localparam int TW   = 64;   // plane numerator total
    localparam int BW   = 43;   // divisor magnitude
    localparam int RW   = 44;   // divider remainder
    localparam int QBW  = 25;   // quotient bits kept before saturation
    localparam int NW   = 80;   // scaled dividend
    localparam int SPLIT = 18;  // low slice of a split multiplier operand

    localparam logic [QBW-1:0] Q_POS_LIM = 25'd8388607;
    localparam logic [QBW-1:0] Q_NEG_LIM = 25'd8388608;
    localparam logic signed [23:0] HEIGHT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] HEIGHT_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [15:0] v0_x;
        logic signed [15:0] v0_y;
        logic signed [15:0] v0_z;
        logic signed [15:0] v1_x;
        logic signed [15:0] v1_y;
        logic signed [15:0] v1_z;
        logic signed [15:0] v2_x;
        logic signed [15:0] v2_y;
        logic signed [15:0] v2_z;
        logic signed [23:0] query_x;
        logic signed [23:0] query_z;
        logic [15:0]        surface_tag;
    } t_in_word;

    typedef struct packed {
        logic               inside_res;
        logic               hit;
        logic signed [23:0] height;
        logic [15:0]        surface_out;
    } t_out_word;

    typedef struct packed {
        logic               in_tri;
        logic signed [PW-1:0] den;
        logic signed [PW-1:0] a_coef;
        logic signed [PW-1:0] b_coef;
        logic signed [QW-1:0] x0q;
        logic signed [QW-1:0] z0q;
        logic signed [15:0] y0;
        logic [15:0]        tag;
    } t_front;

    typedef struct packed {
        logic [RW-1:0]  rem;
        logic [QBW-1:0] num_lo;
        logic [BW-1:0]  div;
        logic [QBW-1:0] quo;
        logic           ovf;
        logic           neg;
        logic           in_tri;
        logic           hit;
        logic [15:0]    tag;
    } t_div;

endpackage

/* src/tph_geom.sv */
// Edge test and plane coefficient stages of the triangle point height block.
`timescale 1ns / 1ps

module tph_geom #(
    parameter int COORD_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tph_pkg::t_in_word i_word,
    output logic              o_valid,
    output tph_pkg::t_front   o_front
);
    import tph_pkg::*;

    localparam int SH = 16 - COORD_BITS;

    function automatic logic signed [15:0] sx(input logic [15:0] v);
        logic [15:0] t;
        t = v << SH;
        return $signed(t) >>> SH;
    endfunction

    function automatic logic signed [QW-1:0] rel(input logic signed [15:0] c,
                                                 input logic signed [23:0] q);
        return $signed({c[15], c, 8'b0}) - $signed({q[23], q});
    endfunction

    function automatic logic signed [DW-1:0] dif(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        return $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    // Stage 1: sign extension, query-relative vertices, differences.
    logic signed [15:0] w_x0, w_x1, w_x2, w_y0, w_y1, w_y2, w_z0, w_z1, w_z2;
    logic                 r_v1;
    logic signed [QW-1:0] r_xq0, r_xq1, r_xq2, r_zq0, r_zq1, r_zq2;
    logic signed [DW-1:0] r_x01, r_x12, r_y01, r_y12, r_z01, r_z12;
    logic signed [15:0]   r_y0_1;
    logic [15:0]          r_tag1;

    assign w_x0 = sx(i_word.v0_x);
    assign w_x1 = sx(i_word.v1_x);
    assign w_x2 = sx(i_word.v2_x);
    assign w_y0 = sx(i_word.v0_y);
    assign w_y1 = sx(i_word.v1_y);
    assign w_y2 = sx(i_word.v2_y);
    assign w_z0 = sx(i_word.v0_z);
    assign w_z1 = sx(i_word.v1_z);
    assign w_z2 = sx(i_word.v2_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_xq0  <= rel(w_x0, i_word.query_x);
        r_xq1  <= rel(w_x1, i_word.query_x);
        r_xq2  <= rel(w_x2, i_word.query_x);
        r_zq0  <= rel(w_z0, i_word.query_z);
        r_zq1  <= rel(w_z1, i_word.query_z);
        r_zq2  <= rel(w_z2, i_word.query_z);
        r_x01  <= dif(w_x0, w_x1);
        r_x12  <= dif(w_x1, w_x2);
        r_y01  <= dif(w_y0, w_y1);
        r_y12  <= dif(w_y1, w_y2);
        r_z01  <= dif(w_z0, w_z1);
        r_z12  <= dif(w_z1, w_z2);
        r_y0_1 <= w_y0;
        r_tag1 <= i_word.surface_tag;
    end

    // Stage 2: all products.
    logic                    r_v2;
    logic signed [PEW-1:0]   r_e0a, r_e0b, r_e1a, r_e1b, r_e2a, r_e2b;
    logic signed [2*DW-1:0]  r_da, r_db, r_aa, r_ab, r_ba, r_bb;
    logic signed [QW-1:0]    r_xq0_2, r_zq0_2;
    logic signed [15:0]      r_y0_2;
    logic [15:0]             r_tag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_e0a   <= r_xq1 * r_zq2;
        r_e0b   <= r_zq1 * r_xq2;
        r_e1a   <= r_xq2 * r_zq0;
        r_e1b   <= r_zq2 * r_xq0;
        r_e2a   <= r_xq0 * r_zq1;
        r_e2b   <= r_zq0 * r_xq1;
        r_da    <= r_z01 * r_x12;
        r_db    <= r_x01 * r_z12;
        r_aa    <= r_y01 * r_z12;
        r_ab    <= r_z01 * r_y12;
        r_ba    <= r_x01 * r_y12;
        r_bb    <= r_y01 * r_x12;
        r_xq0_2 <= r_xq0;
        r_zq0_2 <= r_zq0;
        r_y0_2  <= r_y0_1;
        r_tag2  <= r_tag1;
    end

    // Stage 3: edge signs, inside test, coefficient differences.
    logic signed [PEW:0] w_e0, w_e1, w_e2;
    logic                w_any_pos, w_any_neg;
    logic                r_v3;
    t_front              r_front;

    assign w_e0 = $signed({r_e0a[PEW-1], r_e0a}) - $signed({r_e0b[PEW-1], r_e0b});
    assign w_e1 = $signed({r_e1a[PEW-1], r_e1a}) - $signed({r_e1b[PEW-1], r_e1b});
    assign w_e2 = $signed({r_e2a[PEW-1], r_e2a}) - $signed({r_e2b[PEW-1], r_e2b});
    assign w_any_pos = (w_e0 > 0) || (w_e1 > 0) || (w_e2 > 0);
    assign w_any_neg = w_e0[PEW] || w_e1[PEW] || w_e2[PEW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_front.in_tri <= !(w_any_pos && w_any_neg);
        r_front.den    <= $signed({r_da[2*DW-1], r_da}) - $signed({r_db[2*DW-1], r_db});
        r_front.a_coef <= $signed({r_aa[2*DW-1], r_aa}) - $signed({r_ab[2*DW-1], r_ab});
        r_front.b_coef <= $signed({r_ba[2*DW-1], r_ba}) - $signed({r_bb[2*DW-1], r_bb});
        r_front.x0q    <= r_xq0_2;
        r_front.z0q    <= r_zq0_2;
        r_front.y0     <= r_y0_2;
        r_front.tag    <= r_tag2;
    end

    assign o_valid = r_v3;
    assign o_front = r_front;

endmodule

/* src/tph_numer.sv */
// Numerator assembly and divider setup stages of the triangle point height block.
`timescale 1ns / 1ps

module tph_numer #(
    parameter int FRAC_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tph_pkg::t_front i_front,
    output logic            o_valid,
    output tph_pkg::t_div   o_div
);
    import tph_pkg::*;

    // Stage 4: split products of the wide coefficients.
    logic signed [QW+SPLIT:0]    r_xa_lo, r_zb_lo;
    logic signed [QW+PW-SPLIT-1:0] r_xa_hi, r_zb_hi;
    logic signed [16+SPLIT:0]    r_yd_lo;
    logic signed [16+PW-SPLIT-1:0] r_yd_hi;
    logic signed [PW-1:0]        r_den4;
    logic                        r_v4, r_in4;
    logic [15:0]                 r_tag4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
        end
        r_xa_lo <= i_front.x0q * $signed({1'b0, i_front.a_coef[SPLIT-1:0]});
        r_xa_hi <= i_front.x0q * $signed(i_front.a_coef[PW-1:SPLIT]);
        r_zb_lo <= i_front.z0q * $signed({1'b0, i_front.b_coef[SPLIT-1:0]});
        r_zb_hi <= i_front.z0q * $signed(i_front.b_coef[PW-1:SPLIT]);
        r_yd_lo <= i_front.y0 * $signed({1'b0, i_front.den[SPLIT-1:0]});
        r_yd_hi <= i_front.y0 * $signed(i_front.den[PW-1:SPLIT]);
        r_den4  <= i_front.den;
        r_in4   <= i_front.in_tri;
        r_tag4  <= i_front.tag;
    end

    // Stage 5: recombine the partial products.
    logic signed [TW-1:0] r_xa, r_zb, r_yd;
    logic signed [PW-1:0] r_den5;
    logic                 r_v5, r_in5, r_hit5;
    logic [15:0]          r_tag5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_xa   <= (TW'(r_xa_hi) <<< SPLIT) + TW'(r_xa_lo);
        r_zb   <= (TW'(r_zb_hi) <<< SPLIT) + TW'(r_zb_lo);
        r_yd   <= (TW'(r_yd_hi) <<< SPLIT) + TW'(r_yd_lo);
        r_den5 <= r_den4;
        r_in5  <= r_in4;
        r_hit5 <= r_in4 && (r_den4 != '0);
        r_tag5 <= r_tag4;
    end

    // Stage 6: total numerator and divisor in query units.
    logic signed [TW-1:0] r_total;
    logic signed [BW:0]   r_d;
    logic                 r_v6, r_in6, r_hit6;
    logic [15:0]          r_tag6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_total <= (r_yd <<< 8) + r_xa + r_zb;
        r_d     <= (BW+1)'($signed({r_den5, 8'b0}));
        r_in6   <= r_in5;
        r_hit6  <= r_hit5;
        r_tag6  <= r_tag5;
    end

    // Stage 7: magnitudes and result sign.
    logic [TW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic          r_v7, r_neg7, r_in7, r_hit7;
    logic [15:0]   r_tag7;
    logic [TW-1:0] w_abs_t;
    logic [BW:0]   w_abs_d;

    assign w_abs_t = r_total[TW-1] ? (TW'(0) - r_total) : r_total;
    assign w_abs_d = r_d[BW] ? ((BW+1)'(0) - r_d) : r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
        r_a    <= w_abs_t;
        r_b    <= w_abs_d[BW-1:0];
        r_neg7 <= r_total[TW-1] ^ r_d[BW];
        r_in7  <= r_in6;
        r_hit7 <= r_hit6;
        r_tag7 <= r_tag6;
    end

    // Stage 8: scale the dividend, check for overflow, seed the remainder.
    logic [NW-1:0]     w_n;
    logic [NW-QBW-1:0] w_top;
    logic              r_v8;
    t_div              r_div;

    assign w_n   = {{(NW-TW){1'b0}}, r_a} << FRAC_BITS;
    assign w_top = w_n[NW-1:QBW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= r_v7;
        end
        r_div.rem    <= w_top[RW-1:0];
        r_div.num_lo <= w_n[QBW-1:0];
        r_div.div    <= r_b;
        r_div.quo    <= '0;
        r_div.ovf    <= w_top >= {{(NW-QBW-BW){1'b0}}, r_b};
        r_div.neg    <= r_neg7;
        r_div.in_tri <= r_in7;
        r_div.hit    <= r_hit7;
        r_div.tag    <= r_tag7;
    end

    assign o_valid = r_v8;
    assign o_div   = r_div;

endmodule

/* src/tph_div_step.sv */
// One restoring division stage of the triangle point height block.
`timescale 1ns / 1ps

module tph_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tph_pkg::t_div i_div,
    output logic          o_valid,
    output tph_pkg::t_div o_div
);
    import tph_pkg::*;

    logic [RW-1:0] w_trial;
    logic          w_take;
    logic          r_valid;
    t_div          r_div;

    assign w_trial = {i_div.rem[RW-2:0], i_div.num_lo[QBW-1]};
    assign w_take  = w_trial >= {1'b0, i_div.div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_div.rem    <= w_take ? (w_trial - {1'b0, i_div.div}) : w_trial;
        r_div.num_lo <= {i_div.num_lo[QBW-2:0], 1'b0};
        r_div.div    <= i_div.div;
        r_div.quo    <= {i_div.quo[QBW-2:0], w_take};
        r_div.ovf    <= i_div.ovf;
        r_div.neg    <= i_div.neg;
        r_div.in_tri <= i_div.in_tri;
        r_div.hit    <= i_div.hit;
        r_div.tag    <= i_div.tag;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

/* src/triangle_point_height.sv */
// Top level of the triangle point height block.
`timescale 1ns / 1ps

// Tests a query point against one triangle in the XZ plane and returns the
// plane height there. A word is taken at every rising edge with start high;
// busy is held low, so a new triangle may be issued in every cycle.
// The input word carries three vertices, the query point with eight
// fraction bits and the surface flags. Each result word appears on o_word
// for exactly one cycle, marked by o_valid. A word passes through the edge
// and coefficient stages, the numerator assembly and divider setup stages,
// 25 restoring division stages at one quotient bit each, and one
// saturation stage. Throughput is one word per cycle, set by the fully
// pipelined divider. Results leave in the order the words arrived.
// The receiver cannot stall, so nothing is ever held back.
// Synchronous reset clears every valid bit in flight; words inside the
// pipeline at reset are dropped and no result appears for them.
// The block keeps no state between words.
module triangle_point_height #(
    parameter int FRAC_BITS  = 8,
    parameter int COORD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tph_pkg::t_in_word  i_word,
    output logic               o_valid,
    output tph_pkg::t_out_word o_word
);
    import tph_pkg::*;

    localparam int LATENCY = 3 + 5 + QBW + 1;

    logic   w_front_v;
    t_front w_front;

    // Every stage advances on every clock, so the block is never busy.
    assign busy = 1'b0;

    tph_geom #(
        .COORD_BITS(COORD_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_word  (i_word),
        .o_valid (w_front_v),
        .o_front (w_front)
    );

    logic w_dv [0:QBW];
    t_div w_dd [0:QBW];

    tph_numer #(
        .FRAC_BITS(FRAC_BITS)
    ) u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_v),
        .i_front (w_front),
        .o_valid (w_dv[0]),
        .o_div   (w_dd[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar g = 0; g < QBW; g++) begin : g_div
        tph_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .i_div   (w_dd[g]),
            .o_valid (w_dv[g+1]),
            .o_div   (w_dd[g+1])
        );
    end

    // Saturate the signed quotient and mask it when the test misses.
    t_div              w_last;
    logic signed [23:0] w_height;
    logic              r_valid;
    t_out_word         r_word;

    assign w_last = w_dd[QBW];

    always_comb begin
        if (!w_last.hit) begin
            w_height = '0;
        end else if (w_last.neg) begin
            if (w_last.ovf || (w_last.quo > Q_NEG_LIM)) begin
                w_height = HEIGHT_MIN;
            end else begin
                w_height = 24'(QBW'(0) - w_last.quo);
            end
        end else begin
            if (w_last.ovf || (w_last.quo > Q_POS_LIM)) begin
                w_height = HEIGHT_MAX;
            end else begin
                w_height = w_last.quo[23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dv[QBW];
        end
        r_word.inside_res  <= w_last.in_tri;
        r_word.hit         <= w_last.hit;
        r_word.height      <= w_height;
        r_word.surface_out <= w_last.tag;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

`ifndef ASSERT_OFF
    a_hit_needs_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.hit |-> o_word.inside_res)
        else $error("hit reported for a point outside the triangle");

    a_miss_zero_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.hit |-> (o_word.height == '0))
        else $error("non-zero height on a miss");

    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result word without a matching start");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a free-running pipeline");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the triangle point height block.
`timescale 1ns / 1ps

// Checks triangle_point_height against a predictor written here. Each
// triangle word that the block takes is turned into an expected result word
// and queued. Each result word is compared field by field with the oldest
// entry in that queue. The stimulus has two parts. A short directed part
// covers field extremes, degenerate triangles and points on edges and
// vertices. A random part follows, in which most query points fall inside
// their triangle. The sender idles at a rate that changes from phase to
// phase. A watchdog ends the run if no word moves for too long.
module tb_top;
    import tph_pkg::*;

    // Holds the predicted height results and compares them with the block.
    class height_scoreboard;
        t_out_word expected_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Divides num * 2^8 by den, truncating toward zero and saturating.
        static function longint scaled_div(longint num, longint den);
            bit              neg;
            longint unsigned a, b, q, r, cap;
            neg = (num < 0) != (den < 0);
            a   = (num < 0) ? longint'(-num) : num;
            b   = (den < 0) ? longint'(-den) : den;
            cap = 64'd1 << 30;
            q   = a / b;
            r   = a % b;
            if (q > cap) q = cap;
            for (int i = 0; i < 8; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= b) begin
                    r = r - b;
                    q = q | 1;
                end
                if (q > cap) q = cap;
            end
            if (neg) begin
                if (q > 64'd8388608) return -64'sd8388608;
                return -longint'(q);
            end
            if (q > 64'd8388607) return 64'sd8388607;
            return longint'(q);
        endfunction

        // Works out the result word for one triangle word.
        static function t_out_word height_of(t_in_word w);
            longint    x[3], y[3], z[3], xq[3], zq[3];
            longint    e0, e1, e2, den, num;
            bit        in_tri;
            t_out_word r;
            x[0] = w.v0_x; y[0] = w.v0_y; z[0] = w.v0_z;
            x[1] = w.v1_x; y[1] = w.v1_y; z[1] = w.v1_z;
            x[2] = w.v2_x; y[2] = w.v2_y; z[2] = w.v2_z;
            for (int k = 0; k < 3; k++) begin
                xq[k] = x[k] * 256 - longint'(w.query_x);
                zq[k] = z[k] * 256 - longint'(w.query_z);
            end
            e0 = xq[1] * zq[2] - zq[1] * xq[2];
            e1 = xq[2] * zq[0] - zq[2] * xq[0];
            e2 = xq[0] * zq[1] - zq[0] * xq[1];
            // A zero edge value counts as either sign.
            in_tri = (e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0);
            den = (z[0] - z[1]) * (x[1] - x[2]) - (x[0] - x[1]) * (z[1] - z[2]);
            r.inside_res  = in_tri;
            r.hit         = in_tri && den != 0;
            r.height      = '0;
            r.surface_out = w.surface_tag;
            if (r.hit) begin
                num = xq[0] * ((y[0] - y[1]) * (z[1] - z[2]) - (z[0] - z[1]) * (y[1] - y[2]))
                    + zq[0] * ((x[0] - x[1]) * (y[1] - y[2]) - (y[0] - y[1]) * (x[1] - x[2]));
                r.height = 24'(scaled_div(y[0] * den * 256 + num, den * 256));
            end
            return r;
        endfunction

        function void note(t_in_word w);
            expected_q.insert(expected_q.size(), height_of(w));
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask

        task check(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                report("unexpected result word", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.inside_res !== want.inside_res)
                report("inside_res", got.inside_res, want.inside_res);
            if (got.hit !== want.hit)
                report("hit", got.hit, want.hit);
            if (got.height !== want.height)
                report("height", got.height, want.height);
            if (got.surface_out !== want.surface_out)
                report("surface_out", got.surface_out, want.surface_out);
        endtask
    endclass

    localparam int WATCH_LIMIT = 5000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_valid;
    t_out_word o_word;

    height_scoreboard sb;
    int                idle_pct;
    int                quiet_cycles = 0;

    triangle_point_height uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_word (i_word),
        .o_valid(o_valid),
        .o_word (o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The monitor runs at the rising edge and so sees the values that the
    // edge samples: the testbench drives with nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note(i_word);
            if (o_valid) sb.check(o_word);
            if ((start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCH_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // Offers one word and holds it until the block takes it. Busy is
    // looked at on the falling edge, where it is stable. Each cycle before
    // the offer is idle with a chance of idle_pct percent.
    task send_word(t_in_word w);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Holds the sender back until every expected result has come.
    task drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_word tri_word(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz, int qx, int qz);
        t_in_word w;
        w.v0_x = 16'(ax); w.v0_y = 16'(ay); w.v0_z = 16'(az);
        w.v1_x = 16'(bx); w.v1_y = 16'(by); w.v1_z = 16'(bz);
        w.v2_x = 16'(cx); w.v2_y = 16'(cy); w.v2_z = 16'(cz);
        w.query_x = 24'(qx); w.query_z = 24'(qz);
        w.surface_tag = 16'($urandom);
        return w;
    endfunction

    // Random triangle. Most of the time the query point is put near the
    // centroid so that the division path is exercised.
    function automatic t_in_word random_word();
        t_in_word     w;
        logic [223:0] raw;
        int           spread, cx, cz;
        longint       qx, qz;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = $urandom_range(3) == 0 ? t_in_word'(raw[207:0]) : '0;
        if ($urandom_range(9) < 7) begin
            spread = 1 << $urandom_range(15);
            cx = $urandom_range(65535) - 32768;
            cz = $urandom_range(65535) - 32768;
            w.v0_x = 16'(cx + $urandom_range(spread) - spread / 2);
            w.v1_x = 16'(cx + $urandom_range(spread) - spread / 2);
            w.v2_x = 16'(cx + $urandom_range(spread) - spread / 2);
            w.v0_z = 16'(cz + $urandom_range(spread) - spread / 2);
            w.v1_z = 16'(cz + $urandom_range(spread) - spread / 2);
            w.v2_z = 16'(cz + $urandom_range(spread) - spread / 2);
            w.v0_y = 16'($urandom); w.v1_y = 16'($urandom); w.v2_y = 16'($urandom);
            qx = (longint'(w.v0_x) + w.v1_x + w.v2_x) * 256 / 3
                 + int'($urandom_range(63)) - 32;
            qz = (longint'(w.v0_z) + w.v1_z + w.v2_z) * 256 / 3
                 + int'($urandom_range(63)) - 32;
            w.query_x = 24'(qx);
            w.query_z = 24'(qz);
            w.surface_tag = 16'($urandom);
        end
        return w;
    endfunction

    initial begin
        sb           = new();
        idle_pct     = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_word       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: extremes, degenerate shapes, edges and vertices.
        send_word(tri_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(tri_word(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768, -8388608, -8388608));
        send_word(tri_word(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767, 8388607, 8388607));
        send_word(tri_word(-32768, 32767, -32768, 32767, -32768, -32768,
                           0, 32767, 32767, 0, 0));
        send_word(tri_word(-32768, -32768, -32768, 32767, 32767, -32768,
                           -32768, 32767, 32767, -8388608, -8388608));
        send_word(tri_word(0, 100, 0, 10, 200, 0, 0, 300, 10, 0, 0));
        send_word(tri_word(0, 100, 0, 10, 200, 0, 0, 300, 10, 1280, 0));
        send_word(tri_word(0, 100, 0, 10, 200, 0, 0, 300, 10, 640, 640));
        send_word(tri_word(0, 100, 0, 10, 200, 0, 0, 300, 10, 1, 1));
        send_word(tri_word(0, 100, 0, 10, 200, 0, 0, 300, 10, 5000, 5000));
        send_word(tri_word(0, -7, 0, 3, 5, 0, 0, -11, 3, 77, 101));
        send_word(tri_word(0, 0, 0, 5, 0, 0, 10, 0, 0, 1280, 0));
        send_word(tri_word(0, 0, 0, 5, 0, 0, 10, 0, 0, 1280, 1));
        send_word(tri_word(1, 32767, 0, 0, -32768, 0, 0, 0, 1, 64, 64));
        send_word(tri_word(-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, 0, 32767, -8388608, 8388607));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 85 : 0;
            for (int n = 0; n < 430; n++) begin
                send_word(random_word());
                // A stretch with no idling inside the phases that idle.
                if (n == 200) idle_pct = 0;
                if (n == 300) idle_pct = (phase == 0) ? 19 : (phase == 1) ? 85 : 0;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
